// File: sv/circular_fifo_queue_macros.svh
// Assertion helpers used by the queue RTL.
`ifndef CIRCULAR_FIFO_QUEUE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cfq_pkg.sv
package cfq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CapW  = 5;

  // Operation codes.
  localparam logic [1:0] FuncQuery = 2'd0;
  localparam logic [1:0] FuncEnq   = 2'd1;
  localparam logic [1:0] FuncDeq   = 2'd2;

  // Status codes.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // Value reported for a missing word.
  localparam logic signed [WordW-1:0] NoneWord = -32'sd1;

  // Capacity after reset.
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // One request.
  typedef struct packed {
    logic [1:0]              func;
    logic signed [WordW-1:0] push_value;
  } req_t;

  // One result.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [WordW-1:0] popped_value;
    logic signed [WordW-1:0] front_value;
    logic signed [WordW-1:0] rear_value;
    logic [CapW-1:0]         entry_count;
    logic                    is_empty;
    logic                    is_full;
  } rsp_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic            shift;
    logic            load;
    logic [CapW-1:0] count;
  } cell_ctrl_t;

endpackage

// File: sv/cfq_cell.sv
module cfq_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                            clk_i,
  input  cfq_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [cfq_pkg::WordW-1:0] push_i,
  input  logic signed [cfq_pkg::WordW-1:0] next_i,
  output logic signed [cfq_pkg::WordW-1:0] data_o
);

  logic signed [cfq_pkg::WordW-1:0] data_d, data_q;
  logic                             is_tail;

  // This cell is the first free slot when the count equals its position.
  assign is_tail = (32'(ctrl_i.count) == 32'(Idx));

  // A dequeue moves every word one cell towards the head; an enqueue fills the free slot.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = next_i;
    end else if (ctrl_i.load && is_tail) begin
      data_d = push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: sv/circular_fifo_queue.sv
// The result of a request is strobed on done_o in the cycle after it is accepted.
// Throughput: one request per cycle; busy stays low, as every cell of the chain
// updates in the cycle of acceptance.
// Reset clears the entry count and sets the capacity to 16; word cells are not reset.
// A capacity write empties the queue. The receiver cannot stall results.
module circular_fifo_queue #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  cfq_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic [cfq_pkg::CapW-1:0]      cfg_wdata_i,
  output logic                          done_o,
  output cfq_pkg::rsp_t                 rsp_o
);

  `include "circular_fifo_queue_macros.svh"

  localparam int unsigned CapMax = (MAX_DEPTH > 31) ? 31 : MAX_DEPTH;
  localparam logic [cfq_pkg::CapW-1:0] CapLimit = cfq_pkg::CapW'(CapMax);

  logic [cfq_pkg::CapW-1:0]         cap_q, cap_eff;
  logic [cfq_pkg::CapW-1:0]         count_d, count_q;
  logic signed [cfq_pkg::WordW-1:0] rear_d, rear_q;
  logic signed [cfq_pkg::WordW-1:0] popped_d, popped_q;
  logic [1:0]                       status_d, status_q;
  logic                             done_q;
  logic                             accept, enq_ok, deq_ok;
  cfq_pkg::cell_ctrl_t              ctrl;
  logic signed [cfq_pkg::WordW-1:0] cell_data [MAX_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Capacity in use, saturated to the built depth (at most 31) and at least one.
  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = cfq_pkg::CapW'(1);
    end else if (cap_q > CapLimit) begin
      cap_eff = CapLimit;
    end
  end

  assign enq_ok = accept && (req_i.func == cfq_pkg::FuncEnq) && (count_q < cap_eff);
  assign deq_ok = accept && (req_i.func == cfq_pkg::FuncDeq) && (count_q != '0);

  // Next count, tail word, status and popped word.
  always_comb begin
    count_d  = count_q;
    rear_d   = rear_q;
    status_d = cfq_pkg::StOk;
    popped_d = cfq_pkg::NoneWord;
    if (enq_ok) begin
      count_d = count_q + cfq_pkg::CapW'(1);
      rear_d  = req_i.push_value;
    end else if (deq_ok) begin
      count_d  = count_q - cfq_pkg::CapW'(1);
      popped_d = cell_data[0];
    end
    if (req_i.func == cfq_pkg::FuncEnq && !enq_ok) begin
      status_d = cfq_pkg::StFull;
    end else if (req_i.func == cfq_pkg::FuncDeq && !deq_ok) begin
      status_d = cfq_pkg::StEmpty;
    end
  end

  // Control state; a capacity write flushes the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= cfq_pkg::CapReset;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        count_q <= '0;
      end else if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rear_q   <= rear_d;
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  // Chain of word cells, head in cell 0.
  assign ctrl.shift = deq_ok;
  assign ctrl.load  = enq_ok;
  assign ctrl.count = count_q;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic signed [cfq_pkg::WordW-1:0] next_word;
    if (i == MAX_DEPTH - 1) begin : g_last
      assign next_word = cfq_pkg::NoneWord;
    end else begin : g_mid
      assign next_word = cell_data[i+1];
    end
    cfq_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .push_i (req_i.push_value),
      .next_i (next_word),
      .data_o (cell_data[i])
    );
  end

  // Result view of the state left by the last request.
  assign done_o             = done_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.popped_value = popped_q;
  assign rsp_o.front_value  = (count_q != '0) ? cell_data[0] : cfq_pkg::NoneWord;
  assign rsp_o.rear_value   = (count_q != '0) ? rear_q : cfq_pkg::NoneWord;
  assign rsp_o.entry_count  = count_q;
  assign rsp_o.is_empty     = (count_q == '0);
  assign rsp_o.is_full      = (count_q == cap_eff);

  // Checks on the control path.
  `CFQ_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, accept, done_o, "missing result strobe")
  `CFQ_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= cap_eff, "count above capacity")
  `CFQ_ASSERT_NEXT(a_deq_count, clk_i, rst_ni, deq_ok && !cfg_we_i,
                   count_q == $past(count_q) - cfq_pkg::CapW'(1), "dequeue count slip")
  `CFQ_ASSERT_NEXT(a_full_reject, clk_i, rst_ni,
                   accept && req_i.func == cfq_pkg::FuncEnq && !enq_ok && !cfg_we_i,
                   rsp_o.status == cfq_pkg::StFull && $stable(count_q), "full reject slip")

endmodule

// File: tb/tb_circular_fifo_queue.sv
module tb_circular_fifo_queue;

  localparam int unsigned QueueDepth    = 16;
  localparam int unsigned RingIdxW      = $clog2(QueueDepth);
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PhaseLength   = 95;
  localparam logic [1:0]  FuncUnused    = 2'd3;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic                         busy;
  cfq_pkg::req_t                req_i       = '0;
  logic                         cfg_we_i    = 1'b0;
  logic [cfq_pkg::CapW-1:0]     cfg_wdata_i = '0;
  logic                         done_o;
  cfq_pkg::rsp_t                rsp_o;

  // Requests waiting to be sent, and results still owed by the block.
  cfq_pkg::req_t                request_backlog[$];
  cfq_pkg::rsp_t                awaited_results[$];

  // Shadow copy of the queue contents and the capacity register.
  logic signed [cfq_pkg::WordW-1:0] ring_words[QueueDepth];
  int unsigned                  ring_head     = 0;
  int unsigned                  ring_count    = 0;
  logic [cfq_pkg::CapW-1:0]     capacity_reg  = cfq_pkg::CapReset;

  int unsigned         requests_sent   = 0;
  int unsigned         requests_taken  = 0;
  int unsigned         sender_idle_pct = 14;
  logic                sender_hold     = 1'b1;
  int unsigned         stall_cycles    = 0;
  int unsigned         error_count     = 0;

  circular_fifo_queue #(
    .MAX_DEPTH(QueueDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Works out the result of one request and advances the shadow queue.
  function automatic cfq_pkg::rsp_t predict_queue_result(cfq_pkg::req_t r);
    cfq_pkg::rsp_t res;
    int unsigned   cap;
    cap = (capacity_reg == '0) ? 1 :
          ((capacity_reg > QueueDepth) ? QueueDepth : int'(capacity_reg));
    res.status       = cfq_pkg::StOk;
    res.popped_value = cfq_pkg::NoneWord;
    res.front_value  = cfq_pkg::NoneWord;
    res.rear_value   = cfq_pkg::NoneWord;
    if (ring_head >= cap) ring_head = 0;
    if (ring_count > cap) ring_count = cap;
    if (r.func == cfq_pkg::FuncEnq) begin
      if (ring_count >= cap) begin
        res.status = cfq_pkg::StFull;
      end else begin
        ring_words[RingIdxW'((ring_head + ring_count) % cap)] = r.push_value;
        ring_count++;
      end
    end else if (r.func == cfq_pkg::FuncDeq) begin
      if (ring_count == 0) begin
        res.status = cfq_pkg::StEmpty;
      end else begin
        res.popped_value = ring_words[RingIdxW'(ring_head)];
        ring_head = (ring_head + 1) % cap;
        ring_count--;
      end
    end
    // Any other code leaves the queue as it is.
    if (ring_count != 0) begin
      res.front_value = ring_words[RingIdxW'(ring_head)];
      res.rear_value  = ring_words[RingIdxW'((ring_head + ring_count - 1) % cap)];
    end
    res.entry_count = cfq_pkg::CapW'(ring_count);
    res.is_empty    = (ring_count == 0);
    res.is_full     = (ring_count == cap);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [cfq_pkg::WordW-1:0] got,
                               logic [cfq_pkg::WordW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Sender: a request stays on the port until the block has taken it.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || requests_taken == requests_sent)) begin
      if (!sender_hold && request_backlog.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        req_i         <= request_backlog.pop_front();
        start         <= 1'b1;
        requests_sent <= requests_sent + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each strobed result, then records what was accepted.
  always @(posedge clk_i) begin
    cfq_pkg::rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result strobed with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", cfq_pkg::WordW'(rsp_o.status),
                        cfq_pkg::WordW'(want.status));
          compare_field("popped_value", rsp_o.popped_value, want.popped_value);
          compare_field("front_value", rsp_o.front_value, want.front_value);
          compare_field("rear_value", rsp_o.rear_value, want.rear_value);
          compare_field("entry_count", cfq_pkg::WordW'(rsp_o.entry_count),
                        cfq_pkg::WordW'(want.entry_count));
          compare_field("is_empty", cfq_pkg::WordW'(rsp_o.is_empty),
                        cfq_pkg::WordW'(want.is_empty));
          compare_field("is_full", cfq_pkg::WordW'(rsp_o.is_full),
                        cfq_pkg::WordW'(want.is_full));
        end
      end
      // A capacity write also empties the queue.
      if (cfg_we_i) begin
        capacity_reg = cfg_wdata_i;
        ring_head    = 0;
        ring_count   = 0;
      end
      if (start && !busy) begin
        awaited_results.push_back(predict_queue_result(req_i));
        requests_taken <= requests_taken + 1;
      end
      // Watchdog on cycles in which nothing moves.
      if (done_o || (start && !busy) || cfg_we_i) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic void add_request(logic [1:0] func, logic [cfq_pkg::WordW-1:0] value);
    cfq_pkg::req_t r;
    r.func       = func;
    r.push_value = value;
    request_backlog.push_back(r);
  endfunction

  function automatic logic [cfq_pkg::WordW-1:0] pick_word();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic release_sender();
    @(posedge clk_i);
    sender_hold = 1'b0;
  endtask

  // Holds the sender and waits for every outstanding result.
  task automatic drain_results();
    @(posedge clk_i);
    sender_hold = 1'b1;
    do @(negedge clk_i);
    while (requests_taken != requests_sent || awaited_results.size() != 0);
  endtask

  task automatic finish_phase();
    while (request_backlog.size() != 0) @(posedge clk_i);
    drain_results();
  endtask

  // Called at a falling edge with the block idle.
  task automatic write_capacity(logic [cfq_pkg::CapW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [cfq_pkg::CapW-1:0] cap_plan[12];
    int unsigned              roll;
    int unsigned              enq_bias;
    logic [1:0]               func;
    cap_plan = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd2, 5'd17,
                 5'd3, 5'd8, 5'd16, 5'd5, 5'd0, 5'd30};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: pops on empty, unused code, word extremes, drain to empty.
    add_request(cfq_pkg::FuncDeq, 32'h1234_5678);
    add_request(cfq_pkg::FuncQuery, 32'h0);
    add_request(FuncUnused, 32'h0);
    add_request(cfq_pkg::FuncEnq, 32'h7FFF_FFFF);
    add_request(cfq_pkg::FuncEnq, 32'h8000_0000);
    add_request(cfq_pkg::FuncEnq, 32'hFFFF_FFFF);
    add_request(cfq_pkg::FuncEnq, 32'h0000_0000);
    add_request(cfq_pkg::FuncQuery, 32'hDEAD_BEEF);
    add_request(FuncUnused, 32'hFFFF_FFFF);
    repeat (5) add_request(cfq_pkg::FuncDeq, 32'h0);
    release_sender();
    finish_phase();

    // Capacity zero behaves as one: a second push is rejected.
    write_capacity(5'd0);
    add_request(cfq_pkg::FuncEnq, 32'h5A5A_5A5A);
    add_request(cfq_pkg::FuncEnq, 32'hA5A5_A5A5);
    add_request(cfq_pkg::FuncQuery, 32'h0);
    add_request(cfq_pkg::FuncDeq, 32'h0);
    add_request(cfq_pkg::FuncDeq, 32'h0);
    release_sender();
    finish_phase();

    // Capacity two: the rear wraps round the ring, then a push hits full.
    write_capacity(5'd2);
    add_request(cfq_pkg::FuncEnq, 32'h0000_0011);
    add_request(cfq_pkg::FuncEnq, 32'h0000_0022);
    add_request(cfq_pkg::FuncDeq, 32'h0);
    add_request(cfq_pkg::FuncEnq, 32'h0000_0033);
    add_request(cfq_pkg::FuncEnq, 32'h0000_0044);
    add_request(cfq_pkg::FuncDeq, 32'h0);
    add_request(cfq_pkg::FuncDeq, 32'h0);
    release_sender();
    finish_phase();

    // Random phases, each with its own capacity, push bias and sender idling.
    for (int ph = 0; ph < 12; ph++) begin
      write_capacity((ph == 10) ? cfq_pkg::CapW'($urandom) : cap_plan[ph]);
      sender_idle_pct = (ph < 4) ? 14 : ((ph < 8) ? 60 : 0);
      enq_bias        = (ph % 3 == 0) ? 70 : ((ph % 3 == 1) ? 50 : 35);
      repeat (PhaseLength) begin
        roll = $urandom_range(99);
        if (roll < enq_bias)  func = cfq_pkg::FuncEnq;
        else if (roll < 92)   func = cfq_pkg::FuncDeq;
        else if (roll < 96)   func = cfq_pkg::FuncQuery;
        else                  func = FuncUnused;
        add_request(func, pick_word());
      end
      release_sender();
      // Midway the sender pauses until every result is in.
      while (request_backlog.size() > PhaseLength / 2) @(posedge clk_i);
      drain_results();
      release_sender();
      finish_phase();
    end

    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
